// ===== rtl/psdf_pkg.sv =====
// Package for the per-source duplicate filter.
// Holds the request and result transfer types and the verdict codes; no dependencies.
package psdf_pkg;

	localparam int unsigned ID_W     = 8;
	localparam int unsigned ID_SPACE = 2 ** ID_W;
	localparam int unsigned SERIAL_W = 32;

	typedef enum logic [2:0] {
		VERDICT_FIRST         = 3'd0,
		VERDICT_ADVANCED      = 3'd1,
		VERDICT_LATE_FRESH    = 3'd2,
		VERDICT_REPEAT_NEWEST = 3'd3,
		VERDICT_REPEAT_WINDOW = 3'd4,
		VERDICT_TOO_OLD       = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [ID_W-1:0]     node_id;
		logic [SERIAL_W-1:0] serial;
	} psdf_req_t;

	typedef struct packed {
		logic     accepted;
		verdict_t verdict;
	} psdf_rsp_t;

endpackage

// ===== rtl/per_source_duplicate_filter_unit.sv =====
// Per-source duplicate filter: sliding-window anti-replay check, one table entry per node_id mod NODES.
// Depends on psdf_pkg for the transfer types and verdict codes.
//
// A request (node_id, serial) is taken on any cycle with start high; busy is always low, so
// the unit takes one request every clock cycle. The request is checked in the cycle after it
// is taken, and its result is driven on the result port in the cycle after that, marked by
// strobe for a single cycle; the receiver cannot stall it. The rate is one request per
// cycle, set by the single read-modify-write of the per-source table: the table memory is read
// when a request is taken and written back in the next cycle, and a forwarding register covers
// back-to-back requests from the same source.
// Seen flags live in flip-flops cleared by reset, so no clearing pass is needed after reset.
module per_source_duplicate_filter_unit #(
	parameter int unsigned NODES  = 256,
	parameter int unsigned WINDOW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  psdf_pkg::psdf_req_t request,
	output logic                strobe,
	output psdf_pkg::psdf_rsp_t result
);
	import psdf_pkg::*;

	localparam int unsigned DEPTH = (NODES < ID_SPACE) ? NODES : ID_SPACE;
	localparam int unsigned IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SHW   = $clog2(WINDOW + 1);

	function automatic logic [ID_SPACE-1:0][IDXW-1:0] build_idx_tbl();
		logic [ID_SPACE-1:0][IDXW-1:0] tbl;
		for (int unsigned i = 0; i < ID_SPACE; i++) begin
			tbl[i] = IDXW'(i % NODES);
		end
		return tbl;
	endfunction

	localparam logic [ID_SPACE-1:0][IDXW-1:0] IDX_TBL = build_idx_tbl();

	logic [SERIAL_W-1:0] mem_newest [DEPTH];
	logic [WINDOW-1:0]   mem_marks  [DEPTH];
	logic [DEPTH-1:0]    seen_q;

	logic                valid_s1;
	logic [IDXW-1:0]     idx_s1;
	logic [SERIAL_W-1:0] serial_s1;
	logic [SERIAL_W-1:0] rd_newest_s1;
	logic [WINDOW-1:0]   rd_marks_s1;

	logic                fwd_valid_q;
	logic [IDXW-1:0]     fwd_idx_q;
	logic [SERIAL_W-1:0] fwd_newest_q;
	logic [WINDOW-1:0]   fwd_marks_q;

	logic                strobe_q;
	psdf_rsp_t           result_q;

	logic                take;
	logic [IDXW-1:0]     idx_in;
	logic                cur_seen;
	logic [SERIAL_W-1:0] cur_newest;
	logic [WINDOW-1:0]   cur_marks;
	logic [SERIAL_W:0]   diff_up;
	logic [SERIAL_W-1:0] diff_dn;
	logic                is_older;
	logic                is_equal;
	logic                big_jump;
	logic                in_window;
	logic [WINDOW:0]     slid;
	logic [WINDOW:0]     late_sel;
	logic [WINDOW-1:0]   late_mask;
	logic                late_hit;
	logic [SERIAL_W-1:0] next_newest;
	logic [WINDOW-1:0]   next_marks;
	psdf_rsp_t           rsp_d;

	assign busy   = 1'b0;
	assign take   = start && !busy;
	assign idx_in = IDX_TBL[request.node_id];

	// table read on transfer, written back in the next cycle
	always_ff @(posedge clk) begin
		if (take) begin
			rd_newest_s1 <= mem_newest[idx_in];
			rd_marks_s1  <= mem_marks[idx_in];
		end
		if (valid_s1) begin
			mem_newest[idx_s1] <= next_newest;
			mem_marks[idx_s1]  <= next_marks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			strobe_q    <= 1'b0;
			seen_q      <= '0;
		end else begin
			valid_s1    <= take;
			fwd_valid_q <= valid_s1;
			strobe_q    <= valid_s1;
			if (valid_s1) begin
				seen_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_s1    <= idx_in;
			serial_s1 <= request.serial;
		end
		if (valid_s1) begin
			fwd_idx_q    <= idx_s1;
			fwd_newest_q <= next_newest;
			fwd_marks_q  <= next_marks;
			result_q     <= rsp_d;
		end
	end

	always_comb begin
		cur_seen = seen_q[idx_s1];
		if (fwd_valid_q && (fwd_idx_q == idx_s1)) begin
			cur_newest = fwd_newest_q;
			cur_marks  = fwd_marks_q;
		end else begin
			cur_newest = rd_newest_s1;
			cur_marks  = rd_marks_s1;
		end

		diff_up  = {1'b0, serial_s1} - {1'b0, cur_newest};
		diff_dn  = cur_newest - serial_s1;
		is_older = diff_up[SERIAL_W];
		is_equal = (serial_s1 == cur_newest);

		big_jump  = (diff_up[SERIAL_W-1:0] > SERIAL_W'(WINDOW));
		slid      = {1'b1, cur_marks} >> diff_up[SHW-1:0];

		in_window = (diff_dn <= SERIAL_W'(WINDOW));
		late_sel  = {1'b1, {WINDOW{1'b0}}} >> diff_dn[SHW-1:0];
		late_mask = late_sel[WINDOW-1:0];
		late_hit  = |(cur_marks & late_mask);

		next_newest  = cur_newest;
		next_marks   = cur_marks;
		rsp_d.accepted = 1'b0;
		rsp_d.verdict  = VERDICT_TOO_OLD;
		priority if (!cur_seen) begin
			next_newest    = serial_s1;
			next_marks     = '0;
			rsp_d.accepted = 1'b1;
			rsp_d.verdict  = VERDICT_FIRST;
		end else if (!is_older && !is_equal) begin
			next_newest    = serial_s1;
			next_marks     = big_jump ? '0 : slid[WINDOW-1:0];
			rsp_d.accepted = 1'b1;
			rsp_d.verdict  = VERDICT_ADVANCED;
		end else if (is_equal) begin
			rsp_d.verdict  = VERDICT_REPEAT_NEWEST;
		end else if (in_window) begin
			if (late_hit) begin
				rsp_d.verdict  = VERDICT_REPEAT_WINDOW;
			end else begin
				next_marks     = cur_marks | late_mask;
				rsp_d.accepted = 1'b1;
				rsp_d.verdict  = VERDICT_LATE_FRESH;
			end
		end else begin
			rsp_d.verdict  = VERDICT_TOO_OLD;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> strobe)
		else $error("checked request produced no result strobe");

	a_source_marked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> seen_q[$past(idx_s1)])
		else $error("source not marked seen after a check");

	a_accept_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.accepted == ((result.verdict == VERDICT_FIRST) ||
			(result.verdict == VERDICT_ADVANCED) || (result.verdict == VERDICT_LATE_FRESH))))
		else $error("accepted flag disagrees with verdict");

	a_repeat_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_valid_q && (fwd_idx_q == idx_s1) && (serial_s1 == fwd_newest_q))
		|-> !rsp_d.accepted)
		else $error("same serial accepted twice back to back");
`endif

endmodule
